[hdl/vels_pkg.sv]
package vels_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [7:0] LIMIT_ALL = 8'hFF;
  localparam int MAX_RESULTS = 64;
endpackage

[hdl/vels_ram.sv]
module vels_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/versioned_edge_log_store_core.sv]
// channel | dir | tdata (low bit up)                                 | tuser / tlast
// in_     | in  | source_vertex, dest_vertex, edge_weight, log_limit | command
// out_    | out | neighbour_vertex, neighbour_weight, vertex_degree  | status, valid / last
// A stored insert adds a dest presence write (S_WDST) to an edit request.
// A query over n log entries runs a clear pass that resets the seen bits of the scanned
// destinations, then a scan pass over the same entries.
// A query with n = 0 or on a missing source skips both passes.
// Every result holds while out_tready is low. rst_n is synchronous; after reset a sweep over
// all NUM_VERTICES rows clears the count, degree and presence table while in_tready stays low.
module versioned_edge_log_store_core #(
  parameter int NUM_VERTICES = 256,
  parameter int LOG_DEPTH    = 64,
  parameter int WEIGHT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // source_vertex, dest_vertex, edge_weight, log_limit
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // neighbour_vertex, neighbour_weight, vertex_degree
  output logic        out_tlast,
  output logic [2:0]  out_tuser   // status, neighbour_valid
);
  import vels_pkg::*;

  localparam int VB = $clog2(NUM_VERTICES);
  localparam int CB = $clog2(LOG_DEPTH + 1);
  localparam int AW = $clog2(NUM_VERTICES * LOG_DEPTH);
  localparam int WK = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
  localparam int EW = VB + WK;
  localparam int TW = CB + 9;   // count, degree, present
  localparam int XW = CB + 8;

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RD_SRC = 4'd2, S_RD_DST = 4'd3,
                         S_DEC = 4'd4, S_WDST = 4'd5, S_CLR = 4'd6, S_CLRW = 4'd7,
                         S_SCAN = 4'd8, S_SEEN = 4'd9, S_CHK = 4'd10, S_FIN = 4'd11,
                         S_WAIT = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] cmd_r;
  logic [7:0] src_r, dst_r, lim_r;
  logic [WK-1:0] w_r;
  logic src_ok_r, dst_ok_r;
  logic [TW-1:0] srow_r, drow_r;
  logic [VB:0] sweep_r;
  logic [CB-1:0] idx_r;
  logic [6:0] nout_r;
  logic [EW-1:0] ent_r;
  logic pend_r;
  logic [7:0] pnv_r;
  logic [31:0] pnw_r;
  logic [7:0] onv_r, odeg_r;
  logic [31:0] onw_r;
  logic olast_r, ovalid_r;
  logic [1:0] ostat_r;

  // vertex table: {present, degree, count}
  logic tw_e; logic [VB-1:0] tw_a, tr_a; logic [TW-1:0] tw_d, tr_d;
  vels_ram #(.WIDTH(TW), .DEPTH(NUM_VERTICES)) u_vtab (
    .clk, .we(tw_e), .waddr(tw_a), .wdata(tw_d), .raddr(tr_a), .rdata(tr_d));

  logic lw_e; logic [AW-1:0] lw_a, lr_a; logic [EW-1:0] lw_d, lr_d;
  vels_ram #(.WIDTH(EW), .DEPTH(NUM_VERTICES*LOG_DEPTH)) u_log (
    .clk, .we(lw_e), .waddr(lw_a), .wdata(lw_d), .raddr(lr_a), .rdata(lr_d));

  logic sw_e, sw_d; logic [VB-1:0] sw_a, sr_a; logic sr_d;
  vels_ram #(.WIDTH(1), .DEPTH(NUM_VERTICES)) u_seen (
    .clk, .we(sw_e), .waddr(sw_a), .wdata(sw_d), .raddr(sr_a), .rdata(sr_d));

  logic [CB-1:0] cnt_s; logic [7:0] deg_s; logic pres_s, dpres;
  assign cnt_s  = srow_r[CB-1:0];
  assign deg_s  = srow_r[CB+7:CB];
  assign pres_s = srow_r[TW-1];
  assign dpres  = tr_d[TW-1];   // dest row, valid in S_DEC

  logic [VB-1:0] src_i, dst_i;
  assign src_i = VB'(src_r);
  assign dst_i = VB'(dst_r);

  logic [AW-1:0] base_a;
  assign base_a = AW'(src_i) * AW'(LOG_DEPTH);

  logic [CB-1:0] lim_cnt;
  always_comb begin
    priority if (lim_r == LIMIT_ALL) lim_cnt = cnt_s;
    else if (lim_r[7]) lim_cnt = '0;
    else if (XW'(lim_r[6:0]) < XW'(cnt_s)) lim_cnt = CB'(lim_r[6:0]);
    else lim_cnt = cnt_s;
  end

  logic commit;
  assign commit = (cmd_r != CMD_QUERY) && src_ok_r && dst_ok_r &&
                  (cnt_s < CB'(LOG_DEPTH)) && (cmd_r == CMD_INSERT || (pres_s && dpres));

  logic [7:0] deg_new;
  always_comb begin
    unique case (cmd_r)
      CMD_INSERT: deg_new = deg_s + 8'd1;
      CMD_DELETE: deg_new = deg_s - 8'd1;
      default:    deg_new = deg_s;
    endcase
  end

  logic [VB-1:0] ent_d, rd_d;
  logic [WK-1:0] ent_w;
  assign ent_d = ent_r[EW-1:WK];
  assign ent_w = ent_r[WK-1:0];
  assign rd_d  = lr_d[EW-1:WK];

  logic live;
  assign live = !sr_d && (ent_w != '0) && (nout_r < 7'(MAX_RESULTS));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_WAIT);
  assign out_tdata  = {odeg_r, onw_r, onv_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = {ovalid_r, ostat_r};

  always_comb begin
    tw_e = 1'b0; tw_a = src_i; tr_a = src_i;
    tw_d = {1'b1, deg_new, cnt_s + CB'(1)};
    lw_e = 1'b0; lw_a = base_a + AW'(cnt_s);
    lw_d = {dst_i, (cmd_r == CMD_DELETE) ? {WK{1'b0}} : w_r};
    lr_a = base_a + AW'(idx_r - CB'(1));
    sw_e = 1'b0; sw_a = rd_d; sw_d = 1'b0; sr_a = rd_d;
    unique case (state_r)
      S_INIT: begin
        tw_e = 1'b1; tw_a = sweep_r[VB-1:0]; tw_d = '0;
      end
      S_RD_DST: tr_a = dst_i;
      S_DEC: begin
        tw_e = commit; lw_e = commit;
      end
      S_WDST: begin
        // a self loop already got its presence in the source row write
        tw_e = (src_i != dst_i); tw_a = dst_i; tw_d = {1'b1, drow_r[TW-2:0]};
      end
      S_CLRW: sw_e = 1'b1;
      S_CHK: begin
        sw_e = !sr_d; sw_a = ent_d; sw_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:   if (sweep_r == (VB+1)'(NUM_VERTICES - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_tvalid) state_nxt = S_RD_SRC;
      S_RD_SRC: state_nxt = S_RD_DST;
      S_RD_DST: state_nxt = S_DEC;
      S_DEC: begin
        priority if (cmd_r == CMD_QUERY && src_ok_r && pres_s)
          state_nxt = (lim_cnt == '0) ? S_FIN : S_CLR;
        else if (commit && cmd_r == CMD_INSERT) state_nxt = S_WDST;
        else state_nxt = S_WAIT;
      end
      S_WDST:   state_nxt = S_WAIT;
      S_CLR:    state_nxt = S_CLRW;
      S_CLRW:   state_nxt = (idx_r == '0) ? S_SCAN : S_CLR;
      S_SCAN:   state_nxt = (idx_r == '0) ? S_FIN : S_SEEN;
      S_SEEN:   state_nxt = S_CHK;
      S_CHK:    state_nxt = (live && pend_r) ? S_WAIT : S_SCAN;
      S_FIN:    state_nxt = S_WAIT;
      S_WAIT:   if (out_tready) state_nxt = olast_r ? S_IDLE : S_SCAN;
      default:  state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) sweep_r <= sweep_r + (VB+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        src_r <= in_tdata[7:0]; dst_r <= in_tdata[15:8];
        w_r <= WK'(in_tdata[47:16]); lim_r <= in_tdata[55:48];
        cmd_r <= in_tuser;
        src_ok_r <= 32'(in_tdata[7:0]) < 32'(NUM_VERTICES);
        dst_ok_r <= 32'(in_tdata[15:8]) < 32'(NUM_VERTICES);
      end
      S_RD_DST: srow_r <= tr_d;
      S_DEC: begin
        drow_r <= tr_d;
        onv_r <= '0; onw_r <= '0; ovalid_r <= 1'b0; olast_r <= 1'b1;
        nout_r <= '0; pend_r <= 1'b0; idx_r <= lim_cnt;
        priority if (cmd_r == CMD_QUERY) begin
          ostat_r <= (src_ok_r && pres_s) ? ST_OK : ST_MISSING;
          odeg_r <= src_ok_r ? deg_s : 8'd0;
        end else if (!src_ok_r || !dst_ok_r ||
                     (cmd_r != CMD_INSERT && !(pres_s && dpres))) begin
          ostat_r <= ST_MISSING;
          odeg_r <= src_ok_r ? deg_s : 8'd0;
        end else if (cnt_s >= CB'(LOG_DEPTH)) begin
          ostat_r <= ST_FULL;
          odeg_r <= deg_s;
        end else begin
          ostat_r <= ST_OK;
          odeg_r <= deg_new;
        end
      end
      S_CLR, S_SCAN: if (idx_r != '0) idx_r <= idx_r - CB'(1);
      S_CLRW: if (idx_r == '0) idx_r <= lim_cnt;
      S_SEEN: ent_r <= lr_d;
      // the newest live neighbour is held back until we know whether it is the last
      S_CHK: if (live) begin
        nout_r <= nout_r + 7'd1;
        pend_r <= 1'b1;
        pnv_r <= 8'(ent_d);
        pnw_r <= 32'(ent_w);
        if (pend_r) begin
          onv_r <= pnv_r; onw_r <= pnw_r; ovalid_r <= 1'b1; olast_r <= 1'b0;
        end
      end
      S_FIN: begin
        olast_r <= 1'b1;
        ovalid_r <= pend_r;
        onv_r <= pend_r ? pnv_r : 8'd0;
        onw_r <= pend_r ? pnw_r : 32'd0;
      end
      default: ;
    endcase
  end
endmodule

[hdl/vels_checker.sv]
module vels_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("in ready while result pending");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == 2'd0) else $error("bad status");
  // a result without a neighbour always closes its request
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tlast) else $error("empty result not last");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("reset");
endmodule

bind versioned_edge_log_store_core vels_checker u_chk (.*);
